@@ rtl/core/cav_pkg.sv @@
// Shared types and constants for the amplitude variance block.
// No dependencies; imported by every module under rtl/core.
`default_nettype none
package cav_pkg;
   localparam int MAX_PAIRS = 192;
   localparam int CNT_W     = 8;
   localparam int AMP_W     = 16;
   localparam int S1_W      = 24;
   localparam int S2_W      = 40;
   localparam int VAR_W     = 30;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = 2;

   typedef struct packed {
      logic signed [7:0] i_sample;
      logic signed [7:0] q_sample;
      logic              last_pair;
   } req_type;

   typedef struct packed {
      logic [VAR_W-1:0] variance_q16;
      logic [CNT_W-1:0] subcarrier_count;
   } rsp_type;

   // Item handed from the front part to the back part.
   typedef struct packed {
      logic [16:0] power;
      logic        counted;
      logic        last_pair;
   } work_type;
endpackage
`default_nettype wire

@@ rtl/core/cav_front.sv @@
// Front part: accepts requests, forms the power i*i+q*q and queues work items.
// Depends on cav_pkg.
`default_nettype none
module cav_front
   import cav_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req_data,
   output logic          wk_valid,
   input  wire logic     wk_take,
   output work_type      wk_data
);
   work_type          q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              push;
   logic signed [15:0] i_sq, q_sq;
   work_type          item;

   // Classify the request: power, and whether it is still within the record limit.
   always_comb begin
      i_sq           = req_data.i_sample * req_data.i_sample;
      q_sq           = req_data.q_sample * req_data.q_sample;
      item.power     = 17'(i_sq) + 17'(q_sq);
      item.counted   = (cnt_ff < CNT_W'(MAX_PAIRS));
      item.last_pair = req_data.last_pair;
   end

   assign req_stall = (fill_ff == (QPTR_W+1)'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign wk_valid  = (fill_ff != '0);
   assign wk_data   = q_ff[rd_ff];

   // Queue pointers, fill level and the front's own pair count.
   always_comb begin
      wr_in   = push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = wk_take ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(wk_take);
      cnt_in  = cnt_ff;
      if (push) begin
         if (req_data.last_pair) cnt_in = '0;
         else if (item.counted) cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
         cnt_ff  <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= item;
   end
endmodule
`default_nettype wire

@@ rtl/core/cav_back.sv @@
// Back part: square root, accumulation and the final variance division.
// Depends on cav_pkg.
`default_nettype none
module cav_back
   import cav_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     wk_valid,
   output logic          wk_take,
   input  wire work_type wk_data,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);
   typedef enum logic [2:0] {
      S_IDLE, S_ROOT, S_MULA, S_MULB, S_SUB, S_DIV, S_OUT
   } state_type;

   state_type         state_ff;
   logic [33:0]       rad_ff;     // remaining radicand
   logic [33:0]       root_ff;
   logic [33:0]       bit_ff;
   logic              last_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [S1_W-1:0]   s1_ff;
   logic [S2_W-1:0]   s2_ff;
   logic [47:0]       a_ff, b_ff;
   logic [47:0]       rem_ff;
   logic [VAR_W-1:0]  quo_ff;
   logic [5:0]        step_ff;
   logic [15:0]       nn_ff;
   rsp_type           out_ff;
   logic [33:0]       trial;
   logic [31:0]       sq;

   assign wk_take   = (state_ff == S_IDLE) && wk_valid;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = out_ff;
   assign trial     = root_ff + bit_ff;
   assign sq        = 32'(root_ff[AMP_W-1:0]) * 32'(root_ff[AMP_W-1:0]);

   // Sequencer: one square root step per cycle, then accumulate or finish.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff     <= '0;
         s1_ff    <= '0;
         s2_ff    <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (wk_valid) begin
               rad_ff    <= 34'({wk_data.power, 16'h0});
               root_ff   <= '0;
               bit_ff    <= 34'h1 << 32;
               last_ff   <= wk_data.last_pair;
               state_ff  <= wk_data.counted ? S_ROOT : S_MULA;
            end
            S_ROOT: begin
               // Bit-by-bit square root, one bit pair per cycle.
               if (bit_ff == 34'h0) begin
                  n_ff     <= n_ff + 1'b1;
                  s1_ff    <= s1_ff + S1_W'(root_ff[AMP_W-1:0]);
                  s2_ff    <= s2_ff + S2_W'(sq);
                  state_ff <= last_ff ? S_MULA : S_IDLE;
               end else begin
                  if (rad_ff >= trial) begin
                     rad_ff  <= rad_ff - trial;
                     root_ff <= (root_ff >> 1) + bit_ff;
                  end else begin
                     root_ff <= root_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            S_MULA: begin
               if (!last_ff) state_ff <= S_IDLE;
               else begin
                  a_ff     <= 48'(n_ff) * 48'(s2_ff);
                  nn_ff    <= 16'(n_ff) * 16'(n_ff);
                  state_ff <= S_MULB;
               end
            end
            S_MULB: begin
               b_ff     <= 48'(s1_ff) * 48'(s1_ff);
               state_ff <= S_SUB;
            end
            S_SUB: begin
               rem_ff   <= '0;
               quo_ff   <= '0;
               a_ff     <= (a_ff > b_ff && n_ff >= 8'd2) ? a_ff - b_ff : '0;
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // Restoring division, one quotient bit per cycle over 48 bits.
               if ({rem_ff[46:0], a_ff[47]} >= 48'(nn_ff)) begin
                  rem_ff <= {rem_ff[46:0], a_ff[47]} - 48'(nn_ff);
                  quo_ff <= {quo_ff[VAR_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[46:0], a_ff[47]};
                  quo_ff <= {quo_ff[VAR_W-2:0], 1'b0};
               end
               a_ff    <= a_ff << 1;
               step_ff <= step_ff + 1'b1;
               if (step_ff == 6'd47) state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_stall) begin
               n_ff     <= '0;
               s1_ff    <= '0;
               s2_ff    <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_DIV && step_ff == 6'd47) begin
            out_ff.variance_q16     <= ({rem_ff[46:0], a_ff[47]} >= 48'(nn_ff))
                                       ? {quo_ff[VAR_W-2:0], 1'b1}
                                       : {quo_ff[VAR_W-2:0], 1'b0};
            out_ff.subcarrier_count <= n_ff;
         end
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/csi_amplitude_variance.sv @@
// Top level of the amplitude variance block.
// Depends on cav_pkg, cav_front and cav_back.
//
// Usage:
//   The request channel (req_valid, req_stall, req_data) takes one signed
//   I/Q pair per request; last_pair closes a record. The response channel
//   (rsp_valid, rsp_stall, rsp_data) gives one variance and count per record.
//   The front accepts a request per cycle into a four-entry queue unless
//   the queue is full. The back takes each counted pair in S_IDLE, runs 17
//   square root steps in S_ROOT and then accumulates, and takes no new pair
//   until it is done, so that square root sets the sustained rate. A dropped
//   pair that does not close the record goes through S_MULA back to S_IDLE.
//   On the last pair the back goes on through S_MULA, S_MULB and S_SUB and a
//   division over 48 bits in S_DIV, then the response is valid. Pairs beyond
//   192 in a record are dropped but a last pair still closes it. Synchronous
//   reset clears the queue and all sums. While rsp_stall is high the
//   response holds and the queue fills, then req_stall rises.
`default_nettype none
module csi_amplitude_variance
   import cav_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   logic     wk_valid, wk_take;
   work_type wk_data;

   // Front: classification and queue.
   cav_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .wk_valid, .wk_take, .wk_data
   );

   // Back: arithmetic.
   cav_back u_back (
      .clock, .reset, .wk_valid, .wk_take, .wk_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire
